@@ src/bpps_pkg.sv @@
// ----------------------------------------------------------------------------
// bpps_pkg: shared types and constants for the bit-plane pixel shifter
// Command codes, resolution codes, palette entry layout and RGB565 expansion.
// ----------------------------------------------------------------------------
package bpps_pkg;

  // Input word command codes
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PLANES  = 1'b1;

  // Resolution mode codes
  localparam logic MODE_LOW    = 1'b0;
  localparam logic MODE_MEDIUM = 1'b1;

  localparam int unsigned PLANE_W   = 16;
  localparam int unsigned PAL_DEPTH = 16;

  // Palette entry: blue 2:0, green 5:3, red 8:6
  typedef logic [8:0]  pal_entry_t;
  typedef logic [15:0] rgb565_t;

  // Pack a machine color word (blue 2:0, green 6:4, red 10:8) into an entry
  function automatic pal_entry_t pack_color(input logic [11:0] cw);
    return {cw[10:8], cw[6:4], cw[2:0]};
  endfunction

  // Expand an entry to RGB565: red<<2, green<<3, blue<<2
  function automatic rgb565_t entry_to_rgb565(input pal_entry_t e);
    return {e[8:6], 2'b00, e[5:3], 3'b000, e[2:0], 2'b00};
  endfunction

endpackage

@@ src/bitplane_palette_pixel_shifter_core.sv @@
// ----------------------------------------------------------------------------
// bitplane_palette_pixel_shifter_core: bit-plane to RGB565 shifter
// Stores palette writes and turns plane groups into one pixel per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Flow: a group word is captured into the plane registers; each pixel is then
// looked up in the palette and registered in the output register, advancing
// while out_ready is high or the output is empty. A group gives 16 pixels in
// low resolution, 8 in medium, with a single palette lookup per pixel.
// Reset (rst_n low, synchronous): palette cleared to black, mode low,
// shifter and output register empty.
module bitplane_palette_pixel_shifter_core
  import bpps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [3:0]  in_palette_index,
  input  logic [11:0] in_color_word,
  input  logic [15:0] in_plane0,
  input  logic [15:0] in_plane1,
  input  logic [15:0] in_plane2,
  input  logic [15:0] in_plane3,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_color,
  output logic        out_last_of_group
);

  logic                 mode_r;
  pal_entry_t           pal_r [PAL_DEPTH];
  logic [PLANE_W-1:0]   p0_r, p1_r, p2_r, p3_r;
  logic [3:0]           pos_r;
  logic                 busy_r;
  logic                 out_valid_r;
  rgb565_t              out_color_r;
  logic                 out_last_r;

  logic                 in_acc;
  logic                 advance;
  logic                 med_mode;
  logic                 pix_last;
  logic [3:0]           pix_idx;
  logic [3:0]           pos_nxt;

  // Pixel selection and shift control
  assign med_mode = (mode_r == MODE_MEDIUM);
  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign pix_last = med_mode ? (pos_r == 4'd1) : (pos_r == 4'd0);
  assign pos_nxt  = pos_r - (med_mode ? 4'd2 : 4'd1);
  assign pix_idx  = med_mode ? {2'b00, p1_r[pos_r], p0_r[pos_r]}
                             : {p3_r[pos_r], p2_r[pos_r], p1_r[pos_r], p0_r[pos_r]};

  // Take a new word when the shifter is empty or hands off its last pixel
  assign in_ready = !busy_r || (advance && pix_last);
  assign in_acc   = in_valid && in_ready;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LOW;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Palette store, cleared to black at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        pal_r[i] <= '0;
      end
    end else if (in_acc && in_cmd == CMD_PALETTE) begin
      pal_r[in_palette_index] <= pack_color(in_color_word);
    end
  end

  // Plane word holding registers
  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_PLANES) begin
      p0_r <= in_plane0;
      p1_r <= in_plane1;
      p2_r <= in_plane2;
      p3_r <= in_plane3;
    end
  end

  // Shift position and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= 4'd15;
    end else if (in_acc && in_cmd == CMD_PLANES) begin
      busy_r <= 1'b1;
      pos_r  <= 4'd15;
    end else if (advance) begin
      busy_r <= !pix_last;
      pos_r  <= pos_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_color_r <= entry_to_rgb565(pal_r[pix_idx]);
      out_last_r  <= pix_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_color   = out_color_r;
  assign out_last_of_group = out_last_r;

endmodule

@@ src/bpps_checker.sv @@
// ----------------------------------------------------------------------------
// bpps_checker: port-level checks for the bit-plane pixel shifter
// Watches the top-level ports only; bound to the core below.
// ----------------------------------------------------------------------------
module bpps_checker
  import bpps_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_color,
  input logic        out_last_of_group
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_color)
                                && $stable(out_last_of_group))
    else $error("result word changed while stalled");

  // An accepted plane group shows a pixel once it has passed the shift and output registers
  a_group_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_PLANES |=> ##1 out_valid)
    else $error("no pixel after plane group accepted");

  // Ready drops only after a plane group was taken
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !in_ready && $past(in_ready)
      |-> $past(in_valid) && $past(in_cmd) == CMD_PLANES)
    else $error("input ready dropped without a plane group");

  // A palette write into an idle block (output empty now and at the prior
  // sample, so no group is shifting) never produces a result word
  a_pal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid && $past(!out_valid)
      && in_ready && in_valid && in_cmd == CMD_PALETTE |=> !out_valid)
    else $error("palette write produced a result");

endmodule

bind bitplane_palette_pixel_shifter_core bpps_checker u_bpps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_cmd            (in_cmd),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pixel_color   (out_pixel_color),
  .out_last_of_group (out_last_of_group)
);
